// File: rtl/mhpq_pkg.sv
// Shared types and codes for the min-heap priority queue.
// Holds the request and response beat structs and the heap entry layout.
// No dependencies.
package mhpq_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 3;

    // Operation codes
    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                    func;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        source_index;
    } mhpq_req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] min_key;
        logic [TAG_W-1:0]        min_source;
        logic [3:0]              fill_count;
    } mhpq_rsp_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        source;
    } mhpq_entry_t;

endpackage

// File: rtl/mhpq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Parameterized by word width and depth; no dependencies.
module mhpq_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/mhpq_cmp.sv
// Shared signed key comparator used by both sift directions.
// Depends on mhpq_pkg for the key width.
module mhpq_cmp
    import mhpq_pkg::*;
(
    input  logic signed [KEY_W-1:0] a,
    input  logic signed [KEY_W-1:0] b,
    output logic                    less
);

    // Strict signed less-than: ties never move an entry
    assign less = (a < b);

endmodule

// File: rtl/min_heap_priority_queue_top.sv
// Top level of the min-heap priority queue: sequencer, heap RAM and comparator.
// Depends on mhpq_pkg, mhpq_ram and mhpq_cmp.
//
//   channel | direction | handshake           | beat
//   --------+-----------+---------------------+-------------------------------
//   req     | in        | req_valid/req_ready | func, key, source_index
//   rsp     | out       | rsp_valid/rsp_ready | status, min_key, min_source,
//           |           |                     | fill_count
//
// An insert compares each parent as it climbs; an extract reads the root, then the
// last entry, and unless the heap empties sifts down, reading left then right child
// per level; errors go straight to the response. One RAM read port and one comparator
// serve all steps; the next request is taken in the cycle after the response loads.
// Reset clears the entry count, the sequencer and the response valid; RAM contents
// stay undefined until written. A finished operation waits for the response
// register to free up, which holds req_ready low.
module min_heap_priority_queue_top
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  mhpq_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output mhpq_rsp_t rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_UP_RD   = 11'b00000000010,
        S_UP_CMP  = 11'b00000000100,
        S_EX_RD0  = 11'b00000001000,
        S_EX_RD1  = 11'b00000010000,
        S_EX_LAST = 11'b00000100000,
        S_DN_L    = 11'b00001000000,
        S_DN_LC   = 11'b00010000000,
        S_DN_RC   = 11'b00100000000,
        S_DN_MV   = 11'b01000000000,
        S_DONE    = 11'b10000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    mhpq_entry_t cur_reg, cur_next;
    mhpq_entry_t best_reg, best_next;
    logic [1:0]  status_reg, status_next;
    mhpq_entry_t res_reg, res_next;
    logic        rsp_valid_reg, rsp_valid_next;
    mhpq_rsp_t   rsp_reg, rsp_next;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    mhpq_entry_t             wr_data;
    logic [AW-1:0]           rd_addr;
    mhpq_entry_t             rd_data;
    logic signed [KEY_W-1:0] cmp_a;
    logic signed [KEY_W-1:0] cmp_b;
    logic                    cmp_less;

    logic [XW-1:0] left_x;
    logic [XW-1:0] right_x;
    logic [XW-1:0] count_x;
    logic [AW-1:0] parent_idx;
    logic          req_beat;
    logic          rsp_free;

    mhpq_ram #(
        .WIDTH ($bits(mhpq_entry_t)),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mhpq_cmp u_cmp (
        .a    (cmp_a),
        .b    (cmp_b),
        .less (cmp_less)
    );

    // Tree index arithmetic
    assign left_x     = XW'({idx_reg, 1'b1});
    assign right_x    = left_x + XW'(1);
    assign count_x    = XW'(count_reg);
    assign parent_idx = AW'((idx_reg - AW'(1)) >> 1);

    assign req_ready = (state_reg == S_IDLE);
    assign req_beat  = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // Steer the shared comparator by sequencer step
    always_comb
    begin
        cmp_a = rd_data.key;
        cmp_b = cur_reg.key;
        case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = cur_reg.key;
                cmp_b = rd_data.key;
            end
            S_DN_RC:
            begin
                cmp_a = rd_data.key;
                cmp_b = best_reg.key;
            end
            default:
            begin
                cmp_a = rd_data.key;
                cmp_b = cur_reg.key;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        best_idx_next  = best_idx_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = cur_reg;
        rd_addr        = '0;

        // Drop the response beat once taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_beat)
                begin
                    status_next = ST_OK;
                    res_next    = '0;
                    if (req.func == FUNC_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cur_next.key    = req.key;
                            cur_next.source = req.source_index;
                            idx_next        = AW'(count_reg);
                            count_next      = count_reg + CW'(1);
                            state_next      = S_UP_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_EX_RD0;
                    end
                end
            end

            // Sift up: fetch the parent or settle at the root
            S_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr    = parent_idx;
                    state_next = S_UP_CMP;
                end
            end

            // Sift up: pull the parent down while it is strictly greater
            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (cmp_less)
                begin
                    wr_data    = rd_data;
                    idx_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_EX_RD0:
            begin
                rd_addr    = '0;
                state_next = S_EX_RD1;
            end

            // Capture the root, fetch the last entry
            S_EX_RD1:
            begin
                res_next   = rd_data;
                rd_addr    = AW'(count_reg - CW'(1));
                state_next = S_EX_LAST;
            end

            S_EX_LAST:
            begin
                cur_next   = rd_data;
                count_next = count_reg - CW'(1);
                idx_next   = '0;
                if (count_reg == CW'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_L;
                end
            end

            // Sift down: fetch the left child if present
            S_DN_L:
            begin
                if (left_x < count_x)
                begin
                    rd_addr    = AW'(left_x);
                    state_next = S_DN_LC;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
            end

            // Sift down: weigh the left child, fetch the right one
            S_DN_LC:
            begin
                if (cmp_less)
                begin
                    best_next     = rd_data;
                    best_idx_next = AW'(left_x);
                end
                else
                begin
                    best_next     = cur_reg;
                    best_idx_next = idx_reg;
                end
                if (right_x < count_x)
                begin
                    rd_addr    = AW'(right_x);
                    state_next = S_DN_RC;
                end
                else
                begin
                    state_next = S_DN_MV;
                end
            end

            S_DN_RC:
            begin
                if (cmp_less)
                begin
                    best_next     = rd_data;
                    best_idx_next = AW'(right_x);
                end
                state_next = S_DN_MV;
            end

            // Sift down: promote the smaller child or settle here
            S_DN_MV:
            begin
                wr_en = 1'b1;
                if (best_idx_reg == idx_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wr_data    = best_reg;
                    idx_next   = best_idx_reg;
                    state_next = S_DN_L;
                end
            end

            // Hand the result to the response register
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.status     = status_reg;
                    rsp_next.min_key    = res_reg.key;
                    rsp_next.min_source = res_reg.source;
                    rsp_next.fill_count = 4'(count_reg);
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        status_reg   <= status_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (XW'(wr_addr) < count_x))
        else $error("heap write outside the filled region");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_beat && req.func == FUNC_INSERT && count_reg != CW'(CAPACITY))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("accepted insert did not grow the heap");

    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(rsp_valid_reg) && rsp_reg.status == ST_EMPTY)
        |-> (rsp_reg.fill_count == 4'd0))
        else $error("empty status with nonzero fill count");
`endif

endmodule
